[design/aesdec_pkg.sv]
// Package for the AES-128 block decrypt unit.
// Holds the constants, the inverse S-box and the round step functions.
// Depends on nothing.
package aesdec_pkg;

  localparam int unsigned NumKeys  = 11;
  localparam int unsigned KeyIdxW  = 4;
  localparam int unsigned NumInner = 9;
  localparam int unsigned NumStg   = NumInner + 2;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;

  typedef enum logic {
    OP_LOAD_KEY = 1'b0,
    OP_DECRYPT  = 1'b1
  } op_t;

  localparam logic [KeyIdxW-1:0] LastKeyIdx = KeyIdxW'(NumKeys - 1);

  localparam byte_t INV_SBOX [256] = '{
    8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
    8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
    8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
    8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
    8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
    8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
    8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
    8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
    8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
    8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
    8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
    8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
    8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
    8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
    8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
  };

  function automatic byte_t xtime(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  // Constant multiplies used by InvMixColumns.
  function automatic byte_t mul9(input byte_t a);
    byte_t a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a;
  endfunction

  function automatic byte_t mul11(input byte_t a);
    byte_t a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a2 ^ a;
  endfunction

  function automatic byte_t mul13(input byte_t a);
    byte_t a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a4 ^ a;
  endfunction

  function automatic byte_t mul14(input byte_t a);
    byte_t a2, a4, a8;
    a2 = xtime(a);
    a4 = xtime(a2);
    a8 = xtime(a4);
    return a8 ^ a4 ^ a2;
  endfunction

  function automatic byte_t get_byte(input blk_t s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  // InvShiftRows then InvSubBytes; byte i is row i%4, column i/4.
  function automatic blk_t shift_sub(input blk_t s);
    blk_t t;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      for (int unsigned r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = INV_SBOX[get_byte(s, r + 4*((c + 4 - r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t  t;
    byte_t a0, a1, a2, a3;
    t = '0;
    for (int unsigned c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);
      a1 = get_byte(s, 4*c + 1);
      a2 = get_byte(s, 4*c + 2);
      a3 = get_byte(s, 4*c + 3);
      t[127-8*(4*c)   -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      t[127-8*(4*c+1) -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      t[127-8*(4*c+2) -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      t[127-8*(4*c+3) -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    return t;
  endfunction

endpackage

[design/aesdec_if.sv]
// Channel interfaces of the AES-128 block decrypt unit.
// aesdec_in_if carries opcode, key slot and block; aesdec_out_if the plaintext.
// Depends on aesdec_pkg.
interface aesdec_in_if;
  logic                             valid;
  logic                             ready;
  aesdec_pkg::op_t                  opcode;
  logic [aesdec_pkg::KeyIdxW-1:0]   key_index;
  logic [63:0]                      block_high;
  logic [63:0]                      block_low;

  modport source (output valid, opcode, key_index, block_high, block_low, input ready);
  modport sink   (input valid, opcode, key_index, block_high, block_low, output ready);
endinterface

interface aesdec_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;

  modport source (output valid, plain_high, plain_low, input ready);
  modport sink   (input valid, plain_high, plain_low, output ready);
endinterface

[design/aes128_block_decrypt_unit.sv]
// AES-128 inverse cipher, ECB, fully unrolled pipeline.
// Top level of the block; depends on aesdec_pkg and the aesdec_if interfaces.
// A decrypt transaction passes from acceptance to a result on the output
// through eleven register stages: one for the initial AddRoundKey, loaded
// at the accepting edge, one per inner round and one for the final round.
// A new block is accepted every cycle unless stalled. The whole pipeline
// advances together and holds while the result register waits. Round keys are
// held in eleven flip-flop registers, each read by its own round stage; a key
// load is accepted only once the pipeline is empty and yields no result.
module aes128_block_decrypt_unit (
  input logic         clk,
  input logic         rst_n,
  aesdec_in_if.sink   in_ch,
  aesdec_out_if.source out_ch
);
  import aesdec_pkg::*;

  blk_t                  key_r   [NumKeys];
  blk_t                  data_r  [NumStg];
  logic [NumStg-1:0]     vld_r;
  blk_t                  data_nxt[NumStg];
  logic                  adv;
  logic                  pipe_empty;
  logic                  in_acc;
  blk_t                  in_blk;

  assign adv        = !vld_r[NumStg-1] || out_ch.ready;
  assign pipe_empty = !(|vld_r);
  assign in_ch.ready = adv && ((in_ch.opcode == OP_DECRYPT) || pipe_empty);
  assign in_acc     = in_ch.valid && in_ch.ready;
  assign in_blk     = {in_ch.block_high, in_ch.block_low};

  always_ff @(posedge clk) begin
    if (in_acc && (in_ch.opcode == OP_LOAD_KEY) && (in_ch.key_index <= LastKeyIdx)) begin
      key_r[in_ch.key_index] <= in_blk;
    end
  end

  always_comb begin
    data_nxt[0] = in_blk ^ key_r[NumKeys-1];
    for (int unsigned i = 1; i <= NumInner; i++) begin
      data_nxt[i] = inv_mix(shift_sub(data_r[i-1]) ^ key_r[NumKeys-1-i]);
    end
    data_nxt[NumStg-1] = shift_sub(data_r[NumStg-2]) ^ key_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NumStg-2:0], in_acc && (in_ch.opcode == OP_DECRYPT)};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int unsigned i = 0; i < NumStg; i++) begin
        data_r[i] <= data_nxt[i];
      end
    end
  end

  assign out_ch.valid      = vld_r[NumStg-1];
  assign out_ch.plain_high = data_r[NumStg-1][127:64];
  assign out_ch.plain_low  = data_r[NumStg-1][63:0];

`ifndef SYNTHESIS
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.opcode == OP_LOAD_KEY)) |=> !(|vld_r[NumStg-1:1]))
    else $error("key load overlapped a block in flight");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during a stall");

  a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r[NumStg-1]) |-> $past(vld_r[NumStg-2]))
    else $error("result appeared without a block in the last round");
`endif

endmodule
